// ----- hw/rtl/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg
// shared types, constants and helper functions of the byte ring buffer
// ----------------------------------------------------------------------------
package brb_pkg;

   // storage geometry
   localparam int SLOTS        = 1024;
   localparam int MAX_READ_RUN = 64;
   localparam int IDX_W        = $clog2(SLOTS);
   localparam int LEN_W        = 10;
   localparam int CNT_OUT_W    = 10;
   localparam int CMP_W        = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;
   localparam int RUN_W        = $clog2(MAX_READ_RUN + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_PUT     = 2'd0,
      ACT_GET     = 2'd1,
      ACT_PEEK    = 2'd2,
      ACT_DISCARD = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NODATA  = 2'd1,
      ST_NOSPACE = 2'd2,
      ST_TOOLONG = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_GET,
      CMD_PEEK,
      CMD_DISCARD,
      CMD_TOOLONG
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [7:0]       data;
      logic             last;
      logic [LEN_W-1:0] length;
      logic             len_zero;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   // index add modulo the slot count
   function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W+1)'(SLOTS)) begin
         s = s - (IDX_W+1)'(SLOTS);
      end
      return s[IDX_W-1:0];
   endfunction

   // distance from read index to write index modulo the slot count
   function automatic logic [IDX_W-1:0] slot_dist(input logic [IDX_W-1:0] wi,
                                                  input logic [IDX_W-1:0] ri);
      logic [IDX_W:0] d;
      if (wi >= ri) begin
         d = {1'b0, wi} - {1'b0, ri};
      end else begin
         d = {1'b0, wi} + (IDX_W+1)'(SLOTS) - {1'b0, ri};
      end
      return d[IDX_W-1:0];
   endfunction

   // length field to index width
   function automatic logic [IDX_W-1:0] to_idx(input logic [LEN_W-1:0] l);
      logic [31:0] t;
      t = 32'(l);
      return t[IDX_W-1:0];
   endfunction

   // count to the output field width
   function automatic logic [CNT_OUT_W-1:0] to_cnt_out(input logic [IDX_W-1:0] x);
      logic [31:0] t;
      t = 32'(x);
      return t[CNT_OUT_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/byte_ring_buffer_top.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_top
// circular byte store with all-or-nothing put, get, peek and discard
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | action, data_byte, last_byte, length
//   rsp_    | out       | rsp_valid / rsp_stall  | byte_out, byte_valid, status,
//           |           |                        | run_last, used_count, free_count
//
// put, discard and rejected commands are each done by the back end in its idle state.
// get and peek of n bytes start a read run, then move one byte a cycle
// through the registered read port of the byte store while not stalled.
// a two-entry command queue keeps taking requests, until full, while the back end works.
// reset is synchronous and clears indices, staging and queue; store contents
// are not cleared. a stalled response holds, and the back end stops with it.
// ----------------------------------------------------------------------------
module byte_ring_buffer_top import brb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_action,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   input  logic [LEN_W-1:0]     req_length,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_byte_out,
   output logic                 rsp_byte_valid,
   output logic [1:0]           rsp_status,
   output logic                 rsp_run_last,
   output logic [CNT_OUT_W-1:0] rsp_used_count,
   output logic [CNT_OUT_W-1:0] rsp_free_count
);

   q_status_type q_status;
   logic         q_push;
   logic         q_pop;
   cmd_type      push_cmd;
   cmd_type      head_cmd;

   // request decode
   brb_front u_front (
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_length    (req_length),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   // command queue
   brb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // execution and response
   brb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_cmd          (head_cmd),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status),
      .rsp_run_last   (rsp_run_last),
      .rsp_used_count (rsp_used_count),
      .rsp_free_count (rsp_free_count)
   );

   // queue never overruns or underruns
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full command queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty command queue");

   // data bytes only come with ok status
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_valid) |-> (rsp_status == ST_OK))
      else $error("data byte with error status");

   // counts stay consistent
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CNT_OUT_W'(rsp_used_count + rsp_free_count) == CNT_OUT_W'(SLOTS - 1)))
      else $error("used and free counts disagree");

endmodule

// ----- hw/rtl/brb_front.sv -----
// ----------------------------------------------------------------------------
// brb_front
// accepts request transactions, decodes the action and flags runs that are
// too long before they enter the command queue
// ----------------------------------------------------------------------------
module brb_front import brb_pkg::*; (
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_action,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   input  logic [LEN_W-1:0] req_length,
   input  q_status_type     q_status,
   output logic             q_push,
   output cmd_type          q_cmd
);

   logic too_long;

   // backpressure straight from the queue, held off during reset
   assign req_stall = q_status.full || reset;
   assign q_push    = req_valid && !req_stall;
   assign too_long  = req_length > LEN_W'(MAX_READ_RUN);

   // classify the transaction
   always_comb begin
      q_cmd.data     = req_data_byte;
      q_cmd.last     = req_last_byte;
      q_cmd.length   = req_length;
      q_cmd.len_zero = (req_length == '0);
      case (action_type'(req_action))
         ACT_PUT: begin
            q_cmd.op = CMD_PUT;
         end
         ACT_GET: begin
            q_cmd.op = too_long ? CMD_TOOLONG : CMD_GET;
         end
         ACT_PEEK: begin
            q_cmd.op = too_long ? CMD_TOOLONG : CMD_PEEK;
         end
         ACT_DISCARD: begin
            q_cmd.op = CMD_DISCARD;
         end
         default: begin
            q_cmd.op = CMD_DISCARD;
         end
      endcase
   end

endmodule

// ----- hw/rtl/brb_queue.sv -----
// ----------------------------------------------------------------------------
// brb_queue
// short command queue that decouples the front from the back
// ----------------------------------------------------------------------------
module brb_queue import brb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type status
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/brb_back.sv -----
// ----------------------------------------------------------------------------
// brb_back
// executes queued commands against the byte store and drives the response
// register
// ----------------------------------------------------------------------------
module brb_back import brb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              q_cmd,
   input  q_status_type         q_status,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_byte_out,
   output logic                 rsp_byte_valid,
   output logic [1:0]           rsp_status,
   output logic                 rsp_run_last,
   output logic [CNT_OUT_W-1:0] rsp_used_count,
   output logic [CNT_OUT_W-1:0] rsp_free_count
);

   logic [7:0] storage_mem [SLOTS];

   back_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     read_index_ff, read_index_in;
   logic [IDX_W-1:0]     write_index_ff, write_index_in;
   logic [IDX_W-1:0]     staged_count_ff, staged_count_in;
   logic                 staged_overflow_ff, staged_overflow_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 rd_last_ff, rd_last_in;
   logic [RUN_W-1:0]     issue_left_ff, issue_left_in;
   logic [IDX_W-1:0]     run_addr_ff, run_addr_in;
   logic [IDX_W-1:0]     run_used_ff, run_used_in;

   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_byte_valid_ff, rsp_byte_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0]     rsp_used_ff, rsp_used_in;

   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   logic                 mem_rd_en;
   logic [IDX_W-1:0]     mem_rd_addr;
   logic [7:0]           mem_rd_ff;

   logic                 out_free;
   logic                 load;
   logic [IDX_W-1:0]     used;
   logic [IDX_W-1:0]     free;
   logic                 fits;
   logic                 ovf_new;
   logic [IDX_W-1:0]     sc_inc;
   logic                 no_data;
   logic [IDX_W-1:0]     len_idx;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_out   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_byte_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_used_count = to_cnt_out(rsp_used_ff);
   assign rsp_free_count = to_cnt_out(IDX_W'(SLOTS - 1) - rsp_used_ff);

   // committed occupancy and put fit check
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign used     = slot_dist(write_index_ff, read_index_ff);
   assign free     = IDX_W'(SLOTS - 1) - used;
   assign fits     = !staged_overflow_ff && (staged_count_ff < free);
   assign ovf_new  = staged_overflow_ff || !fits;
   assign sc_inc   = staged_count_ff + 1'b1;
   assign no_data  = CMP_W'(q_cmd.length) > CMP_W'(used);
   assign len_idx  = to_idx(q_cmd.length);
   assign load     = (state_ff == BK_RUN) && rd_pend_ff && out_free;
   assign mem_wr_addr = slot_add(write_index_ff, staged_count_ff);

   // command execution and response loading
   always_comb begin
      state_in           = state_ff;
      read_index_in      = read_index_ff;
      write_index_in     = write_index_ff;
      staged_count_in    = staged_count_ff;
      staged_overflow_in = staged_overflow_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rd_pend_in         = rd_pend_ff;
      rd_last_in         = rd_last_ff;
      issue_left_in      = issue_left_ff;
      run_addr_in        = run_addr_ff;
      run_used_in        = run_used_ff;
      rsp_byte_in        = rsp_byte_ff;
      rsp_byte_valid_in  = rsp_byte_valid_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_used_in        = rsp_used_ff;
      q_pop              = 1'b0;
      mem_wr_en          = 1'b0;
      mem_rd_en          = 1'b0;
      mem_rd_addr        = run_addr_ff;

      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty && out_free) begin
               q_pop             = 1'b1;
               rsp_byte_in       = 8'd0;
               rsp_byte_valid_in = 1'b0;
               rsp_last_in       = 1'b1;
               rsp_used_in       = used;
               rsp_status_in     = ST_OK;
               rsp_valid_in      = 1'b1;
               case (q_cmd.op)
                  CMD_PUT: begin
                     // stage the byte, commit at the last one
                     if (fits) begin
                        mem_wr_en       = 1'b1;
                        staged_count_in = sc_inc;
                     end
                     staged_overflow_in = ovf_new;
                     rsp_status_in      = ovf_new ? ST_NOSPACE : ST_OK;
                     if (q_cmd.last) begin
                        if (!ovf_new) begin
                           write_index_in = slot_add(write_index_ff, sc_inc);
                           rsp_used_in    = used + sc_inc;
                        end
                        staged_count_in    = '0;
                        staged_overflow_in = 1'b0;
                     end
                  end
                  CMD_TOOLONG: begin
                     rsp_status_in = ST_TOOLONG;
                  end
                  CMD_GET, CMD_PEEK, CMD_DISCARD: begin
                     if (no_data) begin
                        rsp_status_in = ST_NODATA;
                     end else if (q_cmd.op == CMD_DISCARD) begin
                        read_index_in = slot_add(read_index_ff, len_idx);
                        rsp_used_in   = used - len_idx;
                     end else if (!q_cmd.len_zero) begin
                        // start a read run, results come from the run state
                        rsp_valid_in  = 1'b0;
                        run_addr_in   = read_index_ff;
                        issue_left_in = q_cmd.length[RUN_W-1:0];
                        rd_pend_in    = 1'b0;
                        run_used_in   = used;
                        if (q_cmd.op == CMD_GET) begin
                           read_index_in = slot_add(read_index_ff, len_idx);
                           run_used_in   = used - len_idx;
                        end
                        state_in = BK_RUN;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         BK_RUN: begin
            // move a fetched byte into the response register
            if (load) begin
               rsp_valid_in      = 1'b1;
               rsp_byte_in       = mem_rd_ff;
               rsp_byte_valid_in = 1'b1;
               rsp_status_in     = ST_OK;
               rsp_last_in       = rd_last_ff;
               rsp_used_in       = run_used_ff;
               rd_pend_in        = 1'b0;
               if (rd_last_ff) begin
                  state_in = BK_IDLE;
               end
            end
            // fetch the next byte while the previous one drains
            if ((issue_left_ff != '0) && (!rd_pend_ff || load)) begin
               mem_rd_en     = 1'b1;
               run_addr_in   = slot_add(run_addr_ff, IDX_W'(1));
               issue_left_in = issue_left_ff - 1'b1;
               rd_pend_in    = 1'b1;
               rd_last_in    = (issue_left_ff == RUN_W'(1));
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= BK_IDLE;
         read_index_ff      <= '0;
         write_index_ff     <= '0;
         staged_count_ff    <= '0;
         staged_overflow_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         rd_pend_ff         <= 1'b0;
         rd_last_ff         <= 1'b0;
         issue_left_ff      <= '0;
      end else begin
         state_ff           <= state_in;
         read_index_ff      <= read_index_in;
         write_index_ff     <= write_index_in;
         staged_count_ff    <= staged_count_in;
         staged_overflow_ff <= staged_overflow_in;
         rsp_valid_ff       <= rsp_valid_in;
         rd_pend_ff         <= rd_pend_in;
         rd_last_ff         <= rd_last_in;
         issue_left_ff      <= issue_left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      run_addr_ff       <= run_addr_in;
      run_used_ff       <= run_used_in;
      rsp_byte_ff       <= rsp_byte_in;
      rsp_byte_valid_ff <= rsp_byte_valid_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_used_ff       <= rsp_used_in;
   end

   // byte store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         storage_mem[mem_wr_addr] <= q_cmd.data;
      end
      if (mem_rd_en) begin
         mem_rd_ff <= storage_mem[mem_rd_addr];
      end
   end

endmodule
